// ===== hw/rtl/aecp_pkg.sv =====
// Shared types, character codes and colour palette for the console escape parser.
package aecp_pkg;

  // Default sizes handed to the top level
  localparam int MaxParamsDef = 16;
  localparam int CursorMaxDef = 255;

  // Colours
  localparam logic [23:0] ColorWhite = 24'hFFFFFF;
  localparam logic [23:0] ColorBlack = 24'h000000;

  // C0 control codes
  localparam logic [7:0] ChBs  = 8'h08;
  localparam logic [7:0] ChHt  = 8'h09;
  localparam logic [7:0] ChLf  = 8'h0A;
  localparam logic [7:0] ChVt  = 8'h0B;
  localparam logic [7:0] ChFf  = 8'h0C;
  localparam logic [7:0] ChCr  = 8'h0D;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChSub = 8'h1A;
  localparam logic [7:0] ChEsc = 8'h1B;
  localparam logic [7:0] ChDel = 8'h7F;

  // Printable codes the parser looks at
  localparam logic [7:0] ChLbr   = 8'h5B;  // '['
  localparam logic [7:0] ChComma = 8'h2C;  // ','
  localparam logic [7:0] ChSemi  = 8'h3B;  // ';'
  localparam logic [7:0] ChSgr   = 8'h6D;  // 'm'

  // Controller to datapath commands
  typedef struct packed {
    logic take;   // input transaction accepted this cycle
    logic walk;   // apply one stored parameter read from the RAM
    logic last;   // apply the current parameter and load the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sgr;        // byte on the input ends an SGR sequence
    logic multi;      // stored parameters precede the current one
    logic walk_done;  // the RAM entry being applied is the last stored one
  } sts_t;

  typedef struct packed {
    logic [23:0] fg;
    logic [23:0] bg;
  } colors_t;

  // 16-colour palette, dark half then bright half
  function automatic logic [23:0] palette(input logic [3:0] idx);
    logic [23:0] rgb;
    case (idx)
      4'd0:    rgb = 24'h000000;
      4'd1:    rgb = 24'hD00000;
      4'd2:    rgb = 24'h00D000;
      4'd3:    rgb = 24'hD0D000;
      4'd4:    rgb = 24'h0050D0;
      4'd5:    rgb = 24'hD000D0;
      4'd6:    rgb = 24'h00D0D0;
      4'd7:    rgb = 24'hD0D0D0;
      4'd8:    rgb = 24'h808080;
      4'd9:    rgb = 24'hFF0000;
      4'd10:   rgb = 24'h00FF00;
      4'd11:   rgb = 24'hFFFF00;
      4'd12:   rgb = 24'h0050FF;
      4'd13:   rgb = 24'hFF00FF;
      4'd14:   rgb = 24'h00FFFF;
      default: rgb = 24'hFFFFFF;
    endcase
    return rgb;
  endfunction

  // One SGR code applied to the current colours; zero also stands for empty
  function automatic colors_t sgr_apply(input colors_t cur, input logic [15:0] v);
    colors_t     res;
    logic [15:0] off;
    res = cur;
    off = 16'd0;
    if (v == 16'd0) begin
      res.fg = ColorWhite;
      res.bg = ColorBlack;
    end else if (v >= 16'd30 && v <= 16'd37) begin
      off    = v - 16'd30;
      res.fg = palette({1'b0, off[2:0]});
    end else if (v == 16'd39) begin
      res.fg = ColorWhite;
    end else if (v >= 16'd40 && v <= 16'd47) begin
      off    = v - 16'd40;
      res.bg = palette({1'b0, off[2:0]});
    end else if (v == 16'd49) begin
      res.bg = ColorBlack;
    end else if (v >= 16'd90 && v <= 16'd97) begin
      off    = v - 16'd90;
      res.fg = palette({1'b1, off[2:0]});
    end else if (v >= 16'd100 && v <= 16'd107) begin
      off    = v - 16'd100;
      res.bg = palette({1'b1, off[2:0]});
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/aecp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module aecp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/aecp_ctrl.sv =====
// Controller: handshakes, SGR parameter walk sequencing and output valid.
module aecp_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  input  aecp_pkg::sts_t sts_i,
  output aecp_pkg::cmd_t cmd_o
);
  import aecp_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StLast = 2'd2;

  logic [1:0] fsm_q, fsm_d;
  logic       out_valid_q, out_valid_d;
  logic       take;

  // Input stalls while a walk runs or the result register cannot drain
  assign in_stall_o = (fsm_q != StIdle) || (out_valid_q && out_stall_i);
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    fsm_d       = fsm_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o       = '0;
    unique case (fsm_q)
      StIdle: begin
        cmd_o.take = take;
        if (take) begin
          if (sts_i.sgr) begin
            fsm_d = sts_i.multi ? StWalk : StLast;
          end else begin
            out_valid_d = 1'b1;
          end
        end
      end
      StWalk: begin
        cmd_o.walk = 1'b1;
        if (sts_i.walk_done) begin
          fsm_d = StLast;
        end
      end
      StLast: begin
        cmd_o.last  = 1'b1;
        out_valid_d = 1'b1;
        fsm_d       = StIdle;
      end
      default: begin
        fsm_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // No input transaction is taken while a walk is running
  a_walk_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q != StIdle |-> in_stall_o)
    else $error("input accepted during SGR walk");

  // Result register is empty for the whole walk
  a_walk_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q != StIdle |-> !out_valid_q)
    else $error("result pending during SGR walk");

  // Finishing a walk always presents a result
  a_last_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fsm_q == StLast |=> out_valid_q && fsm_q == StIdle)
    else $error("SGR walk ended without a result");

endmodule

// ===== hw/rtl/aecp_dp.sv =====
// Datapath: parser state, parameter store, cursor, colours and result payload.
module aecp_dp #(
  parameter int MAX_PARAMS = aecp_pkg::MaxParamsDef,
  parameter int CURSOR_MAX = aecp_pkg::CursorMaxDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [7:0]     byte_i,
  input  aecp_pkg::cmd_t cmd_i,
  output aecp_pkg::sts_t sts_o,
  output logic           draw_o,
  output logic [7:0]     glyph_o,
  output logic [7:0]     draw_col_o,
  output logic [7:0]     draw_row_o,
  output logic [23:0]    fg_rgb_o,
  output logic [23:0]    bg_rgb_o,
  output logic [7:0]     cursor_col_o,
  output logic [7:0]     cursor_row_o
);
  import aecp_pkg::*;

  localparam int IW   = $clog2(MAX_PARAMS);
  localparam int CLOG = $clog2(CURSOR_MAX + 1);
  localparam int CW   = (CLOG > 8) ? CLOG : 8;

  localparam logic [IW-1:0] IdxLast = IW'(MAX_PARAMS - 1);
  localparam logic [CW:0]   CurMax  = (CW + 1)'(CURSOR_MAX);

  // Parser state codes
  localparam logic [2:0] PsGround = 3'd0;
  localparam logic [2:0] PsEscape = 3'd1;
  localparam logic [2:0] PsEntry  = 3'd2;
  localparam logic [2:0] PsParam  = 3'd3;
  localparam logic [2:0] PsIgnore = 3'd4;

  logic [2:0]    ps_q, ps_d;
  logic [IW-1:0] idx_q, idx_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [15:0]   cur_q, cur_d;
  logic [CW-1:0] col_q, col_d, row_q, row_d;
  logic [23:0]   fg_q, fg_d, bg_q, bg_d;
  logic          draw_q, draw_d;
  logic [7:0]    glyph_q, glyph_d, dcol_q, dcol_d, drow_q, drow_d;

  logic          is_ctl, is_digit, is_semi, is_comma, is_priv, is_final;
  logic          param_act;
  logic [19:0]   acc;
  logic [15:0]   cur_dig;
  logic [CW:0]   col_inc, row_inc, col_tab;
  logic [CW-1:0] col_sat, row_sat, tab_sat;
  logic          ram_we;
  logic [IW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;
  logic [15:0]   sgr_val;
  colors_t       sgr_res;

  // Stored parameters; a zero value also stands for an empty one
  aecp_ram #(
    .Width(16),
    .Depth(MAX_PARAMS)
  ) u_param_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(cur_q),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign ram_raddr = cmd_i.walk ? cnt_q : '0;

  // Byte classes
  assign is_ctl   = (byte_i < 8'h20) || (byte_i == ChDel);
  assign is_digit = (byte_i >= 8'h30) && (byte_i <= 8'h39);
  assign is_semi  = (byte_i == ChSemi);
  assign is_comma = (byte_i == ChComma);
  assign is_priv  = (byte_i >= 8'h3C) && (byte_i <= 8'h3F);
  assign is_final = (byte_i >= 8'h40) && (byte_i <= 8'h7E);

  // Status towards the controller
  assign sts_o.sgr       = !is_ctl && (byte_i == ChSgr) &&
                           ((ps_q == PsEntry) || (ps_q == PsParam));
  assign sts_o.multi     = (idx_q != '0);
  assign sts_o.walk_done = (cnt_q == idx_q);

  // Decimal accumulate, saturating at 16 bits
  assign acc     = ({4'd0, cur_q} << 3) + ({4'd0, cur_q} << 1) + {16'd0, byte_i[3:0]};
  assign cur_dig = (acc > 20'h0FFFF) ? 16'hFFFF : acc[15:0];

  // Saturating cursor moves
  assign col_inc = {1'b0, col_q} + (CW + 1)'(1);
  assign row_inc = {1'b0, row_q} + (CW + 1)'(1);
  assign col_tab = {1'b0, col_q[CW-1:3], 3'b000} + (CW + 1)'(8);
  assign col_sat = (col_inc > CurMax) ? CurMax[CW-1:0] : col_inc[CW-1:0];
  assign row_sat = (row_inc > CurMax) ? CurMax[CW-1:0] : row_inc[CW-1:0];
  assign tab_sat = (col_tab > CurMax) ? CurMax[CW-1:0] : col_tab[CW-1:0];

  // SGR unit, fed from the RAM during the walk and from the current value last
  assign sgr_val = cmd_i.last ? cur_q : ram_rdata;
  assign sgr_res = sgr_apply('{fg: fg_q, bg: bg_q}, sgr_val);

  // Next-state logic
  always_comb begin
    ps_d      = ps_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    col_d     = col_q;
    row_d     = row_q;
    fg_d      = fg_q;
    bg_d      = bg_q;
    draw_d    = draw_q;
    glyph_d   = glyph_q;
    dcol_d    = dcol_q;
    drow_d    = drow_q;
    ram_we    = 1'b0;
    param_act = 1'b0;

    if (cmd_i.walk || cmd_i.last) begin
      fg_d = sgr_res.fg;
      bg_d = sgr_res.bg;
    end
    if (cmd_i.walk) begin
      cnt_d = cnt_q + IW'(1);
    end
    if (cmd_i.last) begin
      draw_d  = 1'b0;
      glyph_d = 8'd0;
      dcol_d  = 8'd0;
      drow_d  = 8'd0;
    end

    if (cmd_i.take) begin
      cnt_d   = IW'(1);
      draw_d  = 1'b0;
      glyph_d = 8'd0;
      dcol_d  = 8'd0;
      drow_d  = 8'd0;
      if (is_ctl) begin
        unique case (byte_i) inside
          ChBs: begin
            if (col_q != '0) begin
              col_d = col_q - CW'(1);
            end
          end
          ChCr: col_d = '0;
          ChLf, ChVt, ChFf: begin
            row_d = row_sat;
            col_d = '0;
          end
          ChHt:         col_d = tab_sat;
          ChCan, ChSub: ps_d = PsGround;
          ChEsc:        ps_d = PsEscape;
          default: ;
        endcase
      end else begin
        unique case (ps_q)
          PsEscape: begin
            if (byte_i == ChLbr) begin
              ps_d  = PsEntry;
              idx_d = '0;
              cur_d = 16'd0;
            end else begin
              ps_d = PsGround;
            end
          end
          PsEntry: begin
            if (is_comma) begin
              ps_d = PsIgnore;
            end else if (is_priv) begin
              ps_d = PsParam;
            end else if (is_digit || is_semi) begin
              ps_d      = PsParam;
              param_act = 1'b1;
            end else if (is_final) begin
              ps_d = PsGround;
            end
          end
          PsParam: begin
            if (is_priv || is_comma) begin
              ps_d = PsIgnore;
            end else if (is_digit || is_semi) begin
              param_act = 1'b1;
            end else if (is_final) begin
              ps_d = PsGround;
            end
          end
          PsIgnore: begin
            if (is_final) begin
              ps_d = PsGround;
            end
          end
          default: begin
            // ground: printable byte draws at the cursor
            draw_d  = 1'b1;
            glyph_d = byte_i;
            dcol_d  = col_q[7:0];
            drow_d  = row_q[7:0];
            col_d   = col_sat;
          end
        endcase
      end

      // Parameter collection; on overflow the last slot is reused
      if (param_act) begin
        if (is_digit) begin
          cur_d = cur_dig;
        end else begin
          cur_d = 16'd0;
          if (idx_q != IdxLast) begin
            ram_we = 1'b1;
            idx_d  = idx_q + IW'(1);
          end
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q  <= PsGround;
      idx_q <= '0;
      cnt_q <= '0;
      cur_q <= 16'd0;
      col_q <= '0;
      row_q <= '0;
      fg_q  <= ColorWhite;
      bg_q  <= ColorBlack;
    end else begin
      ps_q  <= ps_d;
      idx_q <= idx_d;
      cnt_q <= cnt_d;
      cur_q <= cur_d;
      col_q <= col_d;
      row_q <= row_d;
      fg_q  <= fg_d;
      bg_q  <= bg_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    draw_q  <= draw_d;
    glyph_q <= glyph_d;
    dcol_q  <= dcol_d;
    drow_q  <= drow_d;
  end

  assign draw_o       = draw_q;
  assign glyph_o      = glyph_q;
  assign draw_col_o   = dcol_q;
  assign draw_row_o   = drow_q;
  assign fg_rgb_o     = fg_q;
  assign bg_rgb_o     = bg_q;
  assign cursor_col_o = col_q[7:0];
  assign cursor_row_o = row_q[7:0];

  // The walk read address stays between 1 and the current parameter index
  a_walk_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.walk |-> (cnt_q != '0) && (cnt_q <= idx_q))
    else $error("SGR walk outside stored parameters");

endmodule

// ===== hw/rtl/ansi_escape_console_parser.sv =====
// Latency: one result per byte, registered; ordinary bytes give it the cycle after acceptance.
// Throughput: one byte per cycle unless the output stalls; an SGR final byte ('m') holds
// the input while the parameters stored before the last one are applied, then the last one,
// as the single RAM read port delivers one stored parameter per cycle to the SGR unit.
// Reset (asynchronous, active low): parser in ground, cursor at 0,0, white on black,
// parameter index 0; the parameter RAM is not cleared.
module ansi_escape_console_parser #(
  parameter int MAX_PARAMS = aecp_pkg::MaxParamsDef,
  parameter int CURSOR_MAX = aecp_pkg::CursorMaxDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        draw_o,
  output logic [7:0]  glyph_o,
  output logic [7:0]  draw_col_o,
  output logic [7:0]  draw_row_o,
  output logic [23:0] fg_rgb_o,
  output logic [23:0] bg_rgb_o,
  output logic [7:0]  cursor_col_out_o,
  output logic [7:0]  cursor_row_out_o
);
  import aecp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing and handshakes
  aecp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Parser, parameter store and display state
  aecp_dp #(
    .MAX_PARAMS(MAX_PARAMS),
    .CURSOR_MAX(CURSOR_MAX)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_in_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .draw_o      (draw_o),
    .glyph_o     (glyph_o),
    .draw_col_o  (draw_col_o),
    .draw_row_o  (draw_row_o),
    .fg_rgb_o    (fg_rgb_o),
    .bg_rgb_o    (bg_rgb_o),
    .cursor_col_o(cursor_col_out_o),
    .cursor_row_o(cursor_row_out_o)
  );

endmodule

// ===== sim/console_scoreboard_pkg.sv =====
// Byte-level predictor and result scoreboard for the console escape parser bench.
package console_scoreboard_pkg;
  import aecp_pkg::*;

  localparam int unsigned MaxParams    = MaxParamsDef;
  localparam int unsigned CursorMax    = CursorMaxDef;
  localparam int unsigned ParamSat     = 65535;
  localparam int unsigned BrightOffset = 8;

  // Byte ranges the parser distinguishes
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChDigit0  = 8'h30;
  localparam logic [7:0] ChDigit9  = 8'h39;
  localparam logic [7:0] ChPrivLo  = 8'h3C;
  localparam logic [7:0] ChPrivHi  = 8'h3F;
  localparam logic [7:0] ChFinalLo = 8'h40;
  localparam logic [7:0] ChFinalHi = 8'h7E;
  localparam logic [7:0] ChHighLo  = 8'h80;

  // SGR codes
  localparam int SgrReset      = 0;
  localparam int SgrFgLo       = 30;
  localparam int SgrFgHi       = 37;
  localparam int SgrFgDefault  = 39;
  localparam int SgrBgLo       = 40;
  localparam int SgrBgHi       = 47;
  localparam int SgrBgDefault  = 49;
  localparam int SgrFgBrightLo = 90;
  localparam int SgrFgBrightHi = 97;
  localparam int SgrBgBrightLo = 100;
  localparam int SgrBgBrightHi = 107;

  // 16 colours, entry 0 in the lowest slice
  localparam logic [15:0][23:0] PaletteRgb = {
    24'hFFFFFF, 24'h00FFFF, 24'hFF00FF, 24'h0050FF,
    24'hFFFF00, 24'h00FF00, 24'hFF0000, 24'h808080,
    24'hD0D0D0, 24'h00D0D0, 24'hD000D0, 24'h0050D0,
    24'hD0D000, 24'h00D000, 24'hD00000, 24'h000000
  };

  typedef enum logic [2:0] {
    PsGround,
    PsEscape,
    PsCsiEntry,
    PsCsiParam,
    PsCsiIgnore
  } parse_state_e;

  typedef struct packed {
    logic        draw;
    logic [7:0]  glyph;
    logic [7:0]  draw_col;
    logic [7:0]  draw_row;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
    logic [7:0]  cursor_col;
    logic [7:0]  cursor_row;
  } console_result_t;

  function automatic bit is_final(logic [7:0] b);
    return b >= ChFinalLo && b <= ChFinalHi;
  endfunction

  function automatic bit is_private(logic [7:0] b);
    return b >= ChPrivLo && b <= ChPrivHi;
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= ChDigit0 && b <= ChDigit9;
  endfunction

  class console_scoreboard;
    parse_state_e    pstate;
    int unsigned     param_val [MaxParams];
    bit              param_blank [MaxParams];
    int unsigned     param_idx;
    int unsigned     col;
    int unsigned     row;
    logic [23:0]     fg;
    logic [23:0]     bg;
    console_result_t expected_q [$];
    int unsigned     errors;
    int unsigned     checked;
    int unsigned     draws;
    int unsigned     sgr_finals;
    int unsigned     full_lists;
    int unsigned     peak_col;
    int unsigned     peak_row;

    function new();
      pstate     = PsGround;
      param_idx  = 0;
      col        = 0;
      row        = 0;
      fg         = ColorWhite;
      bg         = ColorBlack;
      errors     = 0;
      checked    = 0;
      draws      = 0;
      sgr_finals = 0;
      full_lists = 0;
      peak_col   = 0;
      peak_row   = 0;
    endfunction

    function int unsigned bump(int unsigned v, int unsigned d);
      return (v + d > CursorMax) ? CursorMax : v + d;
    endfunction

    // Final byte: only 'm' touches the colours, every parameter up to the current one counts
    function void end_sequence(logic [7:0] b);
      int unsigned n;
      int unsigned v;
      if (b == ChSgr) begin
        sgr_finals++;
        if (param_idx == MaxParams - 1) full_lists++;
        n = (param_idx + 1 > MaxParams) ? MaxParams : param_idx + 1;
        for (int unsigned i = 0; i < n; i++) begin
          v = param_blank[i] ? 0 : param_val[i];
          if (v == SgrReset) begin
            fg = ColorWhite;
            bg = ColorBlack;
          end else if (v >= SgrFgLo && v <= SgrFgHi) begin
            fg = PaletteRgb[v - SgrFgLo];
          end else if (v == SgrFgDefault) begin
            fg = ColorWhite;
          end else if (v >= SgrBgLo && v <= SgrBgHi) begin
            bg = PaletteRgb[v - SgrBgLo];
          end else if (v == SgrBgDefault) begin
            bg = ColorBlack;
          end else if (v >= SgrFgBrightLo && v <= SgrFgBrightHi) begin
            fg = PaletteRgb[v - SgrFgBrightLo + BrightOffset];
          end else if (v >= SgrBgBrightLo && v <= SgrBgBrightHi) begin
            bg = PaletteRgb[v - SgrBgBrightLo + BrightOffset];
          end
        end
      end
      pstate = PsGround;
    endfunction

    // One byte inside a CSI parameter list
    function void step_param(logic [7:0] b);
      int unsigned k;
      int unsigned v;
      k = (param_idx >= MaxParams) ? MaxParams - 1 : param_idx;
      if (is_private(b) || b == ChComma) begin
        pstate = PsCsiIgnore;
      end else if (is_digit(b)) begin
        v = param_blank[k] ? (b - ChDigit0) : param_val[k] * 10 + (b - ChDigit0);
        param_val[k]   = (v > ParamSat) ? ParamSat : v;
        param_blank[k] = 1'b0;
      end else if (b == ChSemi) begin
        // last slot is reused once the list is full
        if (k + 1 < MaxParams) k++;
        param_idx      = k;
        param_val[k]   = 0;
        param_blank[k] = 1'b1;
      end else if (is_final(b)) begin
        end_sequence(b);
      end
    endfunction

    // Accepted input transaction: advance the model and queue the result it gives
    function void note_byte(logic [7:0] b);
      console_result_t r;
      r = '0;
      if (b < ChSpace || b == ChDel) begin
        case (b) inside
          ChBs: begin
            if (col > 0) col--;
          end
          ChCr: col = 0;
          ChLf, ChVt, ChFf: begin
            row = bump(row, 1);
            col = 0;
          end
          ChHt: col = bump(col - (col % 8), 8);
          ChCan, ChSub: pstate = PsGround;
          ChEsc: pstate = PsEscape;
          default: ;
        endcase
      end else begin
        case (pstate)
          PsEscape: begin
            if (b == ChLbr) begin
              pstate         = PsCsiEntry;
              param_idx      = 0;
              param_val[0]   = 0;
              param_blank[0] = 1'b1;
            end else begin
              pstate = PsGround;
            end
          end
          PsCsiEntry: begin
            if (b == ChComma) begin
              pstate = PsCsiIgnore;
            end else if (is_private(b)) begin
              pstate = PsCsiParam;
            end else if (is_digit(b) || b == ChSemi) begin
              pstate = PsCsiParam;
              step_param(b);
            end else if (is_final(b)) begin
              end_sequence(b);
            end
          end
          PsCsiParam: step_param(b);
          PsCsiIgnore: begin
            if (is_final(b)) pstate = PsGround;
          end
          default: begin
            r.draw     = 1'b1;
            r.glyph    = b;
            r.draw_col = 8'(col);
            r.draw_row = 8'(row);
            col        = bump(col, 1);
            draws++;
          end
        endcase
      end
      r.fg_rgb     = fg;
      r.bg_rgb     = bg;
      r.cursor_col = 8'(col);
      r.cursor_row = 8'(row);
      if (col > peak_col) peak_col = col;
      if (row > peak_row) peak_row = row;
      expected_q.push_back(r);
    endfunction

    function void field_ok(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        errors++;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      end
    endfunction

    // Accepted output transaction: compare against the oldest expectation
    function void check_result(console_result_t got);
      console_result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $error("output transaction with no byte outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      field_ok("draw", want.draw, got.draw);
      field_ok("glyph", want.glyph, got.glyph);
      field_ok("draw_col", want.draw_col, got.draw_col);
      field_ok("draw_row", want.draw_row, got.draw_row);
      field_ok("fg_rgb", want.fg_rgb, got.fg_rgb);
      field_ok("bg_rgb", want.bg_rgb, got.bg_rgb);
      field_ok("cursor_col_out", want.cursor_col, got.cursor_col);
      field_ok("cursor_row_out", want.cursor_row, got.cursor_row);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

// ===== sim/testbench.sv =====
// Top-level bench for the console escape parser: stimulus, handshake drivers and checks.
module testbench;
  import aecp_pkg::*;
  import console_scoreboard_pkg::*;

  localparam int unsigned ResetCycles   = 11;
  localparam int unsigned HoldCycles    = 48;
  localparam int unsigned TailCycles    = 20;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned TabRun        = 34;
  localparam int unsigned RandomBytes   = 45;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        draw;
  logic [7:0]  glyph;
  logic [7:0]  draw_col;
  logic [7:0]  draw_row;
  logic [23:0] fg_rgb;
  logic [23:0] bg_rgb;
  logic [7:0]  cur_col;
  logic [7:0]  cur_row;

  bit          send_idle_en = 1'b0;
  bit          recv_idle_en = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned bytes_sent = 0;
  int unsigned quiet_cycles = 0;

  console_scoreboard sb = new();

  ansi_escape_console_parser dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .byte_in_i        (byte_in),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .draw_o           (draw),
    .glyph_o          (glyph),
    .draw_col_o       (draw_col),
    .draw_row_o       (draw_row),
    .fg_rgb_o         (fg_rgb),
    .bg_rgb_o         (bg_rgb),
    .cursor_col_out_o (cur_col),
    .cursor_row_out_o (cur_row)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Monitor: results first, so a spurious one never meets this edge's expectation
  always @(posedge clk) begin : monitor
    console_result_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.draw       = draw;
        got.glyph      = glyph;
        got.draw_col   = draw_col;
        got.draw_row   = draw_row;
        got.fg_rgb     = fg_rgb;
        got.bg_rgb     = bg_rgb;
        got.cursor_col = cur_col;
        got.cursor_row = cur_row;
        sb.check_result(got);
      end
      if (in_valid && !in_stall) sb.note_byte(byte_in);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request
  initial begin : receiver
    int unsigned gap;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One input transaction, with an occasional idle burst in front of it
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (send_idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Drop valid and hold until every queued result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
    @(posedge clk);
  endtask

  task automatic send_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    if ($urandom_range(0, 9) == 0) send_byte(ChDigit0);
    for (int i = 0; i < digits.len(); i++) send_byte(digits[i]);
  endtask

  // ESC [ [marker] p1;p2;... final ; a negative code leaves that parameter empty
  task automatic send_csi(input int codes[$], input int lead, input logic [7:0] fin);
    send_byte(ChEsc);
    send_byte(ChLbr);
    if (lead >= 0) send_byte(lead[7:0]);
    foreach (codes[i]) begin
      if (i > 0) send_byte(ChSemi);
      if (codes[i] >= 0) send_number(codes[i]);
    end
    send_byte(fin);
  endtask

  function automatic logic [7:0] pick_text();
    logic [7:0] b;
    b = 8'($urandom_range(ChSpace, 8'hFF));
    if (b == ChDel) b = ChSpace;
    return b;
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(0, 8))
      0: return ChBs;
      1: return ChHt;
      2: return ChCr;
      3: return ChLf;
      4: return ChVt;
      5: return ChFf;
      6: return ChDel;
      7: return ($urandom_range(0, 1) != 0) ? ChCan : ChSub;
      default: return 8'($urandom_range(0, ChSpace - 1));
    endcase
  endfunction

  // Bytes that a CSI parameter list passes over, though control codes among them still act
  function automatic logic [7:0] pick_filler();
    case ($urandom_range(0, 3))
      0: return pick_control();
      1: return 8'($urandom_range(ChSpace, ChComma - 1));
      2: return 8'($urandom_range(ChComma + 1, ChDigit0 - 1));
      default: return 8'($urandom_range(ChHighLo, 8'hFF));
    endcase
  endfunction

  function automatic int pick_sgr_code();
    case ($urandom_range(0, 11)) inside
      0: return -1;
      1: return SgrReset;
      2, 3: return $urandom_range(SgrFgLo, SgrFgHi);
      4: return $urandom_range(SgrBgLo, SgrBgHi);
      5: return $urandom_range(SgrFgBrightLo, SgrFgBrightHi);
      6, 7: return $urandom_range(SgrBgBrightLo, SgrBgBrightHi);
      8: return ($urandom_range(0, 1) != 0) ? SgrFgDefault : SgrBgDefault;
      9: return $urandom_range(1, 120);
      10: return $urandom_range(ParamSat - 20, ParamSat + 100000);
      default: return $urandom_range(0, 9);
    endcase
  endfunction

  task automatic send_text(input int unsigned n);
    repeat (n) send_byte(pick_text());
  endtask

  // Well-formed CSI: mostly SGR, sometimes a long list or another final byte
  task automatic send_random_csi();
    int          codes[$];
    int unsigned n;
    int          lead;
    logic [7:0]  fin;
    n    = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 5);
    repeat (n) codes.push_back(pick_sgr_code());
    lead = ($urandom_range(0, 7) == 0) ? int'($urandom_range(ChPrivLo, ChPrivHi)) : -1;
    fin  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(ChFinalLo, ChFinalHi)) : ChSgr;
    send_csi(codes, lead, fin);
  endtask

  // Aborted, diverted or padded sequences
  task automatic send_broken_sequence();
    int unsigned kind;
    kind = $urandom_range(0, 5);
    send_byte(ChEsc);
    if (kind == 0) begin
      send_byte(pick_text());
      return;
    end
    send_byte(ChLbr);
    if (kind == 1) send_byte(ChComma);
    send_number($urandom_range(0, 120));
    case (kind)
      2: send_byte(($urandom_range(0, 1) != 0) ? ChCan : ChSub);
      3: send_byte(8'($urandom_range(ChPrivLo, ChPrivHi)));
      4: send_byte(ChEsc);
      default: repeat ($urandom_range(1, 3)) send_byte(pick_filler());
    endcase
    if (kind != 2) begin
      send_byte(ChSemi);
      send_number($urandom_range(0, 120));
      send_byte(($urandom_range(0, 1) != 0) ? ChSgr : 8'($urandom_range(ChFinalLo, ChFinalHi)));
    end
  endtask

  task automatic run_random(input int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      // change the idling mix now and then so quiet stretches appear too
      if ($urandom_range(0, 11) == 0) begin
        send_idle_en = $urandom_range(0, 2) != 0;
        recv_idle_en = $urandom_range(0, 2) != 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) send_text($urandom_range(1, 12));
      else if (pick < 45) send_byte(pick_control());
      else if (pick < 75) send_random_csi();
      else if (pick < 88) send_broken_sequence();
      else if (pick < 91) repeat (TabRun) send_byte(ChHt);
      else repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    int unsigned lf_sent;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;

    // Directed: byte extremes, cursor controls BS, HT, CR and LF, bright colours, empty last parameter
    send_byte(8'hFF);
    send_byte(ChSpace);
    send_byte(ChFinalHi);
    send_byte(8'h00);
    send_byte(ChBs);
    send_byte(ChHt);
    send_byte(ChCr);
    send_byte(ChLf);
    send_byte(ChDel);
    send_csi('{SgrBgBrightHi, SgrFgBrightHi}, -1, ChSgr);
    send_csi('{SgrFgLo + 1, -1}, -1, ChSgr);
    wait_drained();

    run_random(RandomBytes);

    // Long hold-off on the result side while bytes keep coming
    send_idle_en = 1'b0;
    hold_req     = 1'b1;
    while (hold_req) begin
      if ($urandom_range(0, 2) == 0) send_random_csi();
      else send_text($urandom_range(1, 4));
    end
    wait_drained();

    run_random(RandomBytes);

    // Last stretch without idling: column then row saturation
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    repeat (TabRun) send_byte(ChHt);
    send_text(3);
    lf_sent = 0;
    while (lf_sent < CursorMax + 5) begin
      if ($urandom_range(0, 31) != 0) begin
        case ($urandom_range(0, 2))
          0: send_byte(ChLf);
          1: send_byte(ChVt);
          default: send_byte(ChFf);
        endcase
        lf_sent++;
      end else begin
        send_text($urandom_range(1, 4));
      end
    end
    send_csi('{SgrReset}, -1, ChSgr);
    send_text(4);

    wait_drained();
    repeat (TailCycles) @(posedge clk);

    $display("Covered %0d bytes, %0d results checked: %0d glyph draws, %0d SGR finals",
             bytes_sent, sb.checked, sb.draws, sb.sgr_finals);
    $display("(%0d with a full parameter list); cursor peaked at column %0d, row %0d",
             sb.full_lists, sb.peak_col, sb.peak_row);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/aecp_pkg.sv
hw/rtl/aecp_ram.sv
hw/rtl/aecp_ctrl.sv
hw/rtl/aecp_dp.sv
hw/rtl/ansi_escape_console_parser.sv
sim/console_scoreboard_pkg.sv
sim/testbench.sv
